// File: rtl/modinv_pkg.sv
// Package for the modular inverse core: widths, word types and sequencer states.
`default_nettype none

package modinv_pkg;

    localparam int WIDTH  = 32;
    localparam int COEF_W = WIDTH + 1;
    localparam int CNT_W  = $clog2(WIDTH);

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [WIDTH-1:0] operand_a;
        logic [WIDTH-1:0] modulus_b;
    } operands_t;

    typedef struct packed {
        logic [WIDTH-1:0]        gcd_value;
        logic signed [WIDTH-1:0] coeff_a;
        logic signed [WIDTH-1:0] coeff_b;
        logic [WIDTH-1:0]        inverse;
        logic                    has_inverse;
    } result_t;

    typedef struct packed {
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        coef_t            mult0;
        coef_t            mult1;
    } div_req_t;

    typedef struct packed {
        logic [WIDTH-1:0] remainder;
        coef_t            prod0;
        coef_t            prod1;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_ISSUE,
        ST_STEP_WAIT,
        ST_CHECK,
        ST_RED_ISSUE,
        ST_RED_WAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/modular_inverse_ext_euclid_core.sv
// Extended Euclidean core: gcd, Bezout coefficients and modular inverse of one operand pair.
//
// One operand word in, one result word out. The core runs the extended Euclidean
// algorithm with the larger operand divided by the smaller; every Euclid step is one
// pass of a shared bit-serial divider that also forms quotient times both running
// coefficients. A zero operand skips the division chain. When an inverse exists,
// one more divider pass reduces the operand's coefficient into 0..modulus_b-1.
// operands_ready is high only while the core is idle; a finished result waits in
// the output register without blocking the next operand word.
`default_nettype none

module modular_inverse_ext_euclid_core
    import modinv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      operands_valid,
    output logic           operands_ready,
    input  wire operands_t operands,
    output logic           result_valid,
    input  wire logic      result_ready,
    output result_t        result
);

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic             swap_reg, swap_next;
    logic [WIDTH-1:0] rp_reg, rp_next;
    logic [WIDTH-1:0] rc_reg, rc_next;
    coef_t            pp_reg, pp_next;
    coef_t            pc_reg, pc_next;
    coef_t            qp_reg, qp_next;
    coef_t            qc_reg, qc_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    logic             accept;
    logic             a_zero;
    logic             b_zero;
    coef_t            ca;
    coef_t            cb;
    logic             ca_neg;
    coef_t            ca_abs;
    logic             inv_ok;

    logic             div_start;
    logic             div_done;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    modinv_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .rsp   (div_rsp)
    );

    assign operands_ready = (state_reg == ST_IDLE);
    assign accept = operands_valid && operands_ready;
    assign a_zero = (operands.operand_a == '0);
    assign b_zero = (operands.modulus_b == '0);
    assign ca     = swap_reg ? qp_reg : pp_reg;
    assign cb     = swap_reg ? pp_reg : qp_reg;
    assign ca_neg = ca[COEF_W-1];
    assign ca_abs = ca_neg ? -ca : ca;
    assign inv_ok = (rp_reg == WIDTH'(1)) && (b_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (a_zero || b_zero)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_STEP_ISSUE;
                end
            end
            ST_STEP_ISSUE:
                state_next = ST_STEP_WAIT;
            ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rsp.remainder == '0)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_STEP_ISSUE;
                end
            end
            ST_CHECK:
                state_next = inv_ok ? ST_RED_ISSUE : ST_EMIT;
            ST_RED_ISSUE:
                state_next = ST_RED_WAIT;
            ST_RED_WAIT:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        div_start         = 1'b0;
        div_req.dividend  = rp_reg;
        div_req.divisor   = rc_reg;
        div_req.mult0     = pc_reg;
        div_req.mult1     = qc_reg;

        b_next            = b_reg;
        swap_next         = swap_reg;
        rp_next           = rp_reg;
        rc_next           = rc_reg;
        pp_next           = pp_reg;
        pc_next           = pc_reg;
        qp_next           = qp_reg;
        qc_next           = qc_reg;
        inv_next          = inv_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    b_next = operands.modulus_b;
                    if (a_zero && !b_zero)
                    begin
                        swap_next = 1'b0;
                        rp_next   = operands.modulus_b;
                        pp_next   = '0;
                        qp_next   = COEF_W'(1);
                    end
                    else if (b_zero)
                    begin
                        swap_next = 1'b0;
                        rp_next   = operands.operand_a;
                        pp_next   = COEF_W'(1);
                        qp_next   = '0;
                    end
                    else
                    begin
                        swap_next = !(operands.operand_a > operands.modulus_b);
                        rp_next   = swap_next ? operands.modulus_b : operands.operand_a;
                        rc_next   = swap_next ? operands.operand_a : operands.modulus_b;
                        pp_next   = COEF_W'(1);
                        pc_next   = '0;
                        qp_next   = '0;
                        qc_next   = COEF_W'(1);
                    end
                end
            end
            ST_STEP_ISSUE:
                div_start = 1'b1;
            ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    rp_next = rc_reg;
                    rc_next = div_rsp.remainder;
                    pp_next = pc_reg;
                    pc_next = pp_reg - div_rsp.prod0;
                    qp_next = qc_reg;
                    qc_next = qp_reg - div_rsp.prod1;
                end
            end
            ST_CHECK:
            begin
                if (!inv_ok)
                    inv_next = '0;
            end
            ST_RED_ISSUE:
            begin
                div_start        = 1'b1;
                div_req.dividend = ca_abs[WIDTH-1:0];
                div_req.divisor  = b_reg;
                div_req.mult0    = '0;
                div_req.mult1    = '0;
            end
            ST_RED_WAIT:
            begin
                if (div_done)
                begin
                    if (!ca_neg)
                        inv_next = div_rsp.remainder;
                    else if (div_rsp.remainder == '0)
                        inv_next = '0;
                    else
                        inv_next = b_reg - div_rsp.remainder;
                end
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next       = 1'b1;
                    result_next.gcd_value   = rp_reg;
                    result_next.coeff_a     = ca[WIDTH-1:0];
                    result_next.coeff_b     = cb[WIDTH-1:0];
                    result_next.inverse     = inv_reg;
                    result_next.has_inverse = inv_ok;
                end
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg      <= b_next;
        swap_reg   <= swap_next;
        rp_reg     <= rp_next;
        rc_reg     <= rc_next;
        pp_reg     <= pp_next;
        pc_reg     <= pc_next;
        qp_reg     <= qp_next;
        qc_reg     <= qc_next;
        inv_reg    <= inv_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_step_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP_WAIT && div_done) |-> (div_rsp.remainder < rc_reg))
        else $error("divider remainder not below divisor");

    a_red_only_with_inverse: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED_ISSUE) |-> (rp_reg == WIDTH'(1) && b_reg != '0))
        else $error("reduction started without an inverse");

    a_inverse_flag_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.has_inverse) |-> (result.gcd_value == WIDTH'(1)))
        else $error("inverse flagged with gcd other than one");

    a_no_inverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_inverse) |-> (result.inverse == '0))
        else $error("inverse field nonzero without inverse");

    a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_start)
        else $error("divider started on consecutive cycles");

endmodule

`default_nettype wire

// File: rtl/modinv_divider.sv
// Radix-2 restoring divider that also accumulates quotient times two coefficients.
`default_nettype none

module modinv_divider
    import modinv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire div_req_t req,
    output logic          done,
    output div_rsp_t      rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dq_reg, dq_next;
    logic [WIDTH-1:0] divisor_reg, divisor_next;
    coef_t            m0_reg, m0_next;
    coef_t            m1_reg, m1_next;
    coef_t            acc0_reg, acc0_next;
    coef_t            acc1_reg, acc1_next;

    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;
    logic             take;

    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, divisor_reg};
        take      = !diff[WIDTH];

        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        acc0_next    = acc0_reg;
        acc1_next    = acc1_reg;

        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            dq_next      = req.dividend;
            divisor_next = req.divisor;
            m0_next      = req.mult0;
            m1_next      = req.mult1;
            acc0_next    = '0;
            acc1_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = take ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            dq_next    = {dq_reg[WIDTH-2:0], take};
            acc0_next  = (acc0_reg <<< 1) + (take ? m0_reg : '0);
            acc1_next  = (acc1_reg <<< 1) + (take ? m1_reg : '0);
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        acc0_reg    <= acc0_next;
        acc1_reg    <= acc1_next;
    end

    assign done          = done_reg;
    assign rsp.remainder = rem_reg;
    assign rsp.prod0     = acc0_reg;
    assign rsp.prod1     = acc1_reg;

endmodule

`default_nettype wire
